@@ design/hard_branch_tracking_table_macros.svh @@
// Assertion macros for the hard branch tracking table.
// Used by the top level; no other dependencies.
`ifndef HARD_BRANCH_TRACKING_TABLE_MACROS_SVH
`define HARD_BRANCH_TRACKING_TABLE_MACROS_SVH
// implication checked at every clock edge outside reset
`define HBT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define HBT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ design/hbt_pkg.sv @@
// Shared types and constants for the hard branch tracking table.
// No dependencies.
`default_nettype none
package hbt_pkg;
  localparam int PC_W = 48;
  localparam int CLK_W = 32;
  localparam int AGED_W = 10;
  localparam int CNT_W = 8;

  typedef enum logic [1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_TRAIN  = 2'd1,
    FUNC_AGE    = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_AGE_RD,
    ST_AGE_WB,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic             hit;
    logic             hard_flag;
    logic             replaced;
    logic             incremented;
    logic             allocated;
    logic             dropped;
    logic [AGED_W-1:0] aged_count;
  } result_t;
endpackage
`default_nettype wire

@@ design/hard_branch_tracking_table.sv @@
// Hard branch tracking table: lookup, train and age (a sweep of all sets).
// One item at a time; the set's ways are read from one line memory at once.
// After rst a clearing pass zeroes every set before items flow.
// Result held in an output register until taken; next item accepted after.
// Depends on hbt_pkg, hbt_ctrl and the macros header.
`default_nettype none
`include "hard_branch_tracking_table_macros.svh"
module hard_branch_tracking_table #(
  parameter int NUM_SETS       = 64,
  parameter int NUM_WAYS       = 4,
  parameter int SLOTS_PER_LINE = 2,
  parameter int LINE_BYTES     = 64,
  parameter int COUNTER_MAX    = 3
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [55:0] s_tdata,   // func[1:0], pc[49:2], zero fill
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata    // hit, hard_flag, replaced, incremented,
                                      // allocated, dropped, aged_count[15:6]
);
  localparam int OFF_W = $clog2(LINE_BYTES);
  localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int SLT_W = (SLOTS_PER_LINE > 1) ? $clog2(SLOTS_PER_LINE) : 1;
  localparam int TAG_W = hbt_pkg::PC_W - OFF_W;
  localparam int SETX = $clog2(NUM_SETS);
  localparam int CW = hbt_pkg::CNT_W;
  localparam int PW = hbt_pkg::PC_W;
  localparam int KW = hbt_pkg::CLK_W;
  localparam int AW = hbt_pkg::AGED_W;

  // one way: valid, tag, recency, and its slots
  typedef struct packed {
    logic [SLOTS_PER_LINE-1:0]         sv;
    logic [SLOTS_PER_LINE-1:0][PW-1:0] spc;
    logic [SLOTS_PER_LINE-1:0][CW-1:0] scnt;
    logic                              v;
    logic [TAG_W-1:0]                  tag;
    logic [KW-1:0]                     rec;
  } way_t;
  typedef way_t [NUM_WAYS-1:0] set_t;

  set_t mem [NUM_SETS];
  set_t rd_set, wr_set;
  logic [SET_W-1:0] rd_addr, wr_addr;
  logic wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_set;
    rd_set <= mem[rd_addr];
  end

  hbt_pkg::state_t state;
  logic [1:0] func;
  logic [PW-1:0] pc;
  logic [KW-1:0] use_clock;
  logic [SET_W:0] clr_cnt;
  logic [SET_W:0] age_set;
  hbt_pkg::result_t res, res_next;
  logic [AW+6:0] aged;
  logic [AW+6:0] aged_sum;

  logic in_fire, out_fire;
  assign s_tready = (state == hbt_pkg::ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign m_tvalid = (state == hbt_pkg::ST_OUT);
  assign out_fire = m_tvalid && m_tready;

  hbt_ctrl u_ctrl (
    .clk, .rst, .in_fire, .func(s_tdata[1:0]),
    .clear_done(clr_cnt == SET_W'(NUM_SETS - 1) + (SET_W+1)'(0)),
    .age_done(age_set == (SET_W+1)'(NUM_SETS - 1)),
    .out_fire, .state
  );

  logic [TAG_W-1:0] tag_in;
  logic [SET_W-1:0] set_in;
  assign tag_in = pc[PW-1:OFF_W];
  always_comb begin
    set_in = '0;
    if (NUM_SETS > 1) set_in = SET_W'(tag_in[(SETX>0?SETX:1)-1:0]);
  end

  // read address: the item's set, or the sweep position
  always_comb begin
    rd_addr = set_in;
    if (state == hbt_pkg::ST_IDLE)
      rd_addr = (NUM_SETS > 1) ? SET_W'(s_tdata[2+OFF_W +: (SETX>0?SETX:1)]) : '0;
    else if (state == hbt_pkg::ST_AGE_RD || state == hbt_pkg::ST_AGE_WB)
      rd_addr = age_set[SET_W-1:0];
  end

  // evaluate one set for lookup or train
  logic [NUM_WAYS-1:0] wmatch, widle;
  logic found, ishit, ishard;
  logic [WAY_W-1:0] hw, vic;
  set_t ev_set, ag_set;
  logic [KW-1:0] clk_inc;
  logic [AW+6:0] ag_n;
  assign clk_inc = use_clock + KW'(1);

  always_comb begin
    logic got, done;
    logic [KW-1:0] best;
    way_t w;
    found = 1'b0; hw = '0; ishit = 1'b0; ishard = 1'b0;
    res_next = '0;
    ev_set = rd_set;
    w = rd_set[0];
    done = 1'b0;
    for (int i = 0; i < NUM_WAYS; i++) begin
      wmatch[i] = rd_set[i].v && rd_set[i].tag == tag_in;
      widle[i] = 1'b1;
      for (int s = 0; s < SLOTS_PER_LINE; s++)
        if (rd_set[i].sv[s] && rd_set[i].scnt[s] != '0) widle[i] = 1'b0;
    end
    for (int i = NUM_WAYS - 1; i >= 0; i--)
      if (wmatch[i]) begin found = 1'b1; hw = WAY_W'(i); end
    // victim: first invalid or idle way, else earliest strictly oldest
    got = 1'b0; vic = '0; best = rd_set[0].rec;
    for (int i = 0; i < NUM_WAYS; i++) begin
      if (!got) begin
        if (!rd_set[i].v || widle[i]) begin got = 1'b1; vic = WAY_W'(i); end
        else if (rd_set[i].rec < best) begin best = rd_set[i].rec; vic = WAY_W'(i); end
      end
    end
    if (func == hbt_pkg::FUNC_LOOKUP) begin
      if (found) begin
        w = rd_set[hw];
        for (int s = SLOTS_PER_LINE - 1; s >= 0; s--)
          if (w.sv[s] && w.spc[s] == pc) begin
            ishit = 1'b1; ishard = w.scnt[s] > CW'(2);
          end
        ev_set[hw].rec = clk_inc;
      end
      res_next.hit = ishit; res_next.hard_flag = ishard;
    end else begin
      if (found) w = rd_set[hw];
      else begin
        w = rd_set[vic];
        res_next.replaced = w.v;
        w.v = 1'b1; w.tag = tag_in; w.sv = '0; w.spc = '0; w.scnt = '0;
        hw = vic;
      end
      w.rec = clk_inc;
      done = 1'b0;
      for (int s = 0; s < SLOTS_PER_LINE; s++)
        if (!done && w.sv[s] && w.spc[s] == pc) begin
          if (w.scnt[s] < CW'(COUNTER_MAX)) w.scnt[s] = w.scnt[s] + CW'(1);
          res_next.incremented = 1'b1; done = 1'b1;
        end
      for (int s = 0; s < SLOTS_PER_LINE; s++)
        if (!done && (!w.sv[s] || w.scnt[s] == '0)) begin
          w.sv[s] = 1'b1; w.spc[s] = pc; w.scnt[s] = CW'(1);
          res_next.allocated = 1'b1; done = 1'b1;
        end
      res_next.dropped = !done;
      ev_set[hw] = w;
    end
  end

  // age one set: decrement every live counter of valid ways
  always_comb begin
    ag_set = rd_set;
    ag_n = '0;
    for (int i = 0; i < NUM_WAYS; i++)
      for (int s = 0; s < SLOTS_PER_LINE; s++)
        if (rd_set[i].v && rd_set[i].sv[s] && rd_set[i].scnt[s] != '0) begin
          ag_set[i].scnt[s] = rd_set[i].scnt[s] - CW'(1);
          if (rd_set[i].scnt[s] == CW'(1)) ag_set[i].sv[s] = 1'b0;
          ag_n = ag_n + (AW+7)'(1);
        end
  end

  always_comb begin
    wr_en = 1'b0; wr_addr = set_in; wr_set = ev_set;
    case (state)
      hbt_pkg::ST_CLEAR: begin
        wr_en = 1'b1; wr_addr = clr_cnt[SET_W-1:0]; wr_set = '0;
      end
      hbt_pkg::ST_EVAL: wr_en = (func == hbt_pkg::FUNC_TRAIN) || found;
      hbt_pkg::ST_AGE_WB: begin
        wr_en = 1'b1; wr_addr = age_set[SET_W-1:0]; wr_set = ag_set;
      end
      default: wr_en = 1'b0;
    endcase
  end

  // item registers and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      use_clock <= '0; clr_cnt <= '0; age_set <= '0;
    end else begin
      if (state == hbt_pkg::ST_CLEAR) clr_cnt <= clr_cnt + (SET_W+1)'(1);
      if (in_fire) age_set <= '0;
      if (state == hbt_pkg::ST_AGE_WB) age_set <= age_set + (SET_W+1)'(1);
      if (state == hbt_pkg::ST_EVAL && (func == hbt_pkg::FUNC_TRAIN || found))
        use_clock <= clk_inc;
    end
  end

  // running age total, held at the saturation limit so it never wraps
  assign aged_sum = aged + ag_n;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      func <= s_tdata[1:0]; pc <= s_tdata[2 +: PW]; aged <= '0; res <= '0;
    end
    if (state == hbt_pkg::ST_EVAL) res <= res_next;
    if (state == hbt_pkg::ST_AGE_WB) begin
      res.aged_count <= (aged_sum > (AW+7)'(1023)) ? AW'(1023) : AW'(aged_sum);
      aged <= (aged_sum > (AW+7)'(1023)) ? (AW+7)'(1023) : aged_sum;
    end
  end

  assign m_tdata = {res.aged_count, res.dropped, res.allocated, res.incremented,
                    res.replaced, res.hard_flag, res.hit};

  `HBT_ASSERT_IMP(a_one_owner, m_tvalid, !s_tready, "accept while result pending")
  `HBT_ASSERT_IMP(a_train_one, m_tvalid && func == hbt_pkg::FUNC_TRAIN,
    $countones({res.incremented, res.allocated, res.dropped}) == 1, "train outcome")
  `HBT_ASSERT_IMP(a_hard_hit, m_tvalid && res.hard_flag, res.hit, "hard without hit")
  `HBT_ASSERT_NEXT(a_clk_step, state == hbt_pkg::ST_EVAL && func == hbt_pkg::FUNC_TRAIN,
    use_clock == $past(use_clock) + 32'd1, "use clock not advanced")
endmodule
`default_nettype wire

@@ design/hbt_ctrl.sv @@
// Sequencer for the hard branch tracking table: state register and next state.
// Depends on hbt_pkg.
`default_nettype none
module hbt_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_fire,
  input  wire logic [1:0]     func,
  input  wire logic           clear_done,
  input  wire logic           age_done,
  input  wire logic           out_fire,
  output hbt_pkg::state_t     state
);
  hbt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= hbt_pkg::ST_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      hbt_pkg::ST_CLEAR: if (clear_done) state_next = hbt_pkg::ST_IDLE;
      hbt_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (func == hbt_pkg::FUNC_AGE) state_next = hbt_pkg::ST_AGE_RD;
          else if (func == hbt_pkg::FUNC_NONE) state_next = hbt_pkg::ST_OUT;
          else state_next = hbt_pkg::ST_READ;
        end
      end
      hbt_pkg::ST_READ:   state_next = hbt_pkg::ST_EVAL;
      hbt_pkg::ST_EVAL:   state_next = hbt_pkg::ST_OUT;
      hbt_pkg::ST_AGE_RD: state_next = hbt_pkg::ST_AGE_WB;
      hbt_pkg::ST_AGE_WB: state_next = age_done ? hbt_pkg::ST_OUT : hbt_pkg::ST_AGE_RD;
      hbt_pkg::ST_OUT:    if (out_fire) state_next = hbt_pkg::ST_IDLE;
      default:            state_next = hbt_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ bench/tb_hard_branch_tracking_table.sv @@
// Testbench for the hard branch tracking table: random and directed lookup,
// train and age items checked against a behavioral predictor in a scoreboard.
// Depends on hbt_pkg and the hard_branch_tracking_table top level.
`timescale 1ns / 1ps

module tb_hard_branch_tracking_table;

  localparam int NUM_SETS = 64;
  localparam int NUM_WAYS = 4;
  localparam int SLOTS = 2;
  localparam int LINE_BYTES = 64;
  localparam int COUNTER_MAX = 3;
  localparam int NLINES = NUM_SETS * NUM_WAYS;
  localparam int NSLOTS = NLINES * SLOTS;
  localparam int PW = hbt_pkg::PC_W;
  localparam int AW = hbt_pkg::AGED_W;

  // Predictor of the table plus a queue of expected results.
  class branch_table_scoreboard;
    bit                ln_valid[NLINES];
    bit [41:0]         ln_tag[NLINES];
    bit [31:0]         ln_recency[NLINES];
    bit                sl_valid[NSLOTS];
    bit [PW-1:0]       sl_pc[NSLOTS];
    int unsigned       sl_count[NSLOTS];
    bit [31:0]         use_clock;
    hbt_pkg::result_t  pending[$];
    int                errors;

    function new();
      errors = 0;
      use_clock = 0;
      foreach (ln_valid[i]) begin
        ln_valid[i] = 0;
        ln_tag[i] = '0;
        ln_recency[i] = '0;
      end
      foreach (sl_valid[i]) begin
        sl_valid[i] = 0;
        sl_pc[i] = '0;
        sl_count[i] = 0;
      end
    endfunction

    function int find_line(bit [41:0] lineno, int set);
      for (int w = 0; w < NUM_WAYS; w++)
        if (ln_valid[set*NUM_WAYS+w] && ln_tag[set*NUM_WAYS+w] == lineno)
          return set * NUM_WAYS + w;
      return -1;
    endfunction

    function bit line_idle(int li);
      for (int s = 0; s < SLOTS; s++)
        if (sl_valid[li*SLOTS+s] && sl_count[li*SLOTS+s] != 0) return 0;
      return 1;
    endfunction

    // Note an accepted input item: update the table and queue its result.
    function void note_item(hbt_pkg::func_t op, bit [PW-1:0] pc);
      hbt_pkg::result_t r;
      bit [41:0] lineno;
      int set, li, v, k, aged;
      bit done;
      r = '0;
      lineno = 42'(pc / LINE_BYTES);
      set = int'(lineno % NUM_SETS);
      case (op)
        hbt_pkg::FUNC_LOOKUP: begin
          li = find_line(lineno, set);
          if (li >= 0) begin
            use_clock++;
            ln_recency[li] = use_clock;
            for (int s = 0; s < SLOTS; s++) begin
              k = li * SLOTS + s;
              if (sl_valid[k] && sl_pc[k] == pc) begin
                r.hit = 1;
                r.hard_flag = sl_count[k] > 2;
                break;
              end
            end
          end
        end
        hbt_pkg::FUNC_TRAIN: begin
          done = 0;
          use_clock++;
          li = find_line(lineno, set);
          if (li < 0) begin
            // victim: first way that is invalid or all-idle, else oldest recency
            v = set * NUM_WAYS;
            for (int w = 0; w < NUM_WAYS; w++) begin
              k = set * NUM_WAYS + w;
              if (!ln_valid[k] || line_idle(k)) begin
                v = k;
                break;
              end
              if (ln_recency[k] < ln_recency[v]) v = k;
            end
            r.replaced = ln_valid[v];
            ln_valid[v] = 1;
            ln_tag[v] = lineno;
            for (int s = 0; s < SLOTS; s++) begin
              sl_valid[v*SLOTS+s] = 0;
              sl_count[v*SLOTS+s] = 0;
            end
            li = v;
          end
          ln_recency[li] = use_clock;
          for (int s = 0; s < SLOTS && !done; s++) begin
            k = li * SLOTS + s;
            if (sl_valid[k] && sl_pc[k] == pc) begin
              if (sl_count[k] < COUNTER_MAX) sl_count[k]++;
              r.incremented = 1;
              done = 1;
            end
          end
          for (int s = 0; s < SLOTS && !done; s++) begin
            k = li * SLOTS + s;
            if (!sl_valid[k] || sl_count[k] == 0) begin
              sl_valid[k] = 1;
              sl_pc[k] = pc;
              sl_count[k] = 1;
              r.allocated = 1;
              done = 1;
            end
          end
          if (!done) r.dropped = 1;
        end
        hbt_pkg::FUNC_AGE: begin
          aged = 0;
          for (int l = 0; l < NLINES; l++) begin
            if (!ln_valid[l]) continue;
            for (int s = 0; s < SLOTS; s++) begin
              k = l * SLOTS + s;
              if (!sl_valid[k] || sl_count[k] == 0) continue;
              sl_count[k]--;
              aged++;
              if (sl_count[k] == 0) sl_valid[k] = 0;
            end
          end
          r.aged_count = AW'(aged > 1023 ? 1023 : aged);
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    // Check one result against the oldest expectation.
    function void check_result(hbt_pkg::result_t got);
      hbt_pkg::result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.hit != want.hit || got.hard_flag != want.hard_flag
          || got.replaced != want.replaced || got.incremented != want.incremented
          || got.allocated != want.allocated || got.dropped != want.dropped
          || got.aged_count != want.aged_count) begin
        $display("%0t: mismatch expected %h actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [55:0] s_tdata;   // func[1:0], pc[49:2], zero fill
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // hit, hard_flag, replaced, incremented, allocated,
                          // dropped, aged_count[15:6]

  hard_branch_tracking_table u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  branch_table_scoreboard board = new();

  int  send_idle_pct;   // sender idle chance, percent
  int  recv_stall_pct;  // receiver stall chance, percent
  bit  hold_off;        // long receiver hold-off in progress

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  // Receiver: stall at random, or fully during a hold-off. The result
  // fields are packed hit in bit 0 upward, so unpack by name.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        hbt_pkg::result_t got;
        got.hit = m_tdata[0];
        got.hard_flag = m_tdata[1];
        got.replaced = m_tdata[2];
        got.incremented = m_tdata[3];
        got.allocated = m_tdata[4];
        got.dropped = m_tdata[5];
        got.aged_count = m_tdata[15:6];
        board.check_result(got);
      end
      m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Note the input when it is taken by the block.
  always @(posedge clk)
    if (!rst && s_tvalid && s_tready)
      board.note_item(hbt_pkg::func_t'(s_tdata[1:0]), s_tdata[49:2]);

  // Offer one item and hold it until accepted; drop valid only while idle.
  task automatic send_item(hbt_pkg::func_t op, bit [PW-1:0] pc);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {6'b0, pc, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Pick a pc from a small pool of lines so sets conflict and ways fill up.
  function automatic bit [PW-1:0] pick_pc();
    bit [PW-1:0] pc;
    int pick;
    pick = $urandom_range(99);
    if (pick < 85) begin
      // set 0..3, tag 0..7, one of four branches within the line
      pc = (48'($urandom_range(7)) * NUM_SETS + $urandom_range(3)) * LINE_BYTES
           + $urandom_range(3) * 4;
    end else begin
      pc = PW'({$urandom, $urandom});
    end
    return pc;
  endfunction

  function automatic hbt_pkg::func_t pick_op();
    int p;
    p = $urandom_range(99);
    if (p < 40) return hbt_pkg::FUNC_LOOKUP;
    if (p < 94) return hbt_pkg::FUNC_TRAIN;
    if (p < 97) return hbt_pkg::FUNC_AGE;
    return hbt_pkg::FUNC_NONE;
  endfunction

  task automatic random_phase(int n, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) send_item(pick_op(), pick_pc());
  endtask

  initial begin
    bit [PW-1:0] base;
    int wait_cycles;
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    hold_off = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (6) @(posedge clk);
    rst <= 0;

    // Directed: lookup on empty table, extreme pcs, saturation, full line,
    // eviction, aging down to zero, and the unused op code.
    send_item(hbt_pkg::FUNC_LOOKUP, '0);
    send_item(hbt_pkg::FUNC_LOOKUP, '1);
    send_item(hbt_pkg::FUNC_TRAIN, '1);
    send_item(hbt_pkg::FUNC_LOOKUP, '1);
    repeat (4) send_item(hbt_pkg::FUNC_TRAIN, 48'h40);
    send_item(hbt_pkg::FUNC_LOOKUP, 48'h40);
    send_item(hbt_pkg::FUNC_TRAIN, 48'h44);
    send_item(hbt_pkg::FUNC_TRAIN, 48'h48);          // line full: dropped
    send_item(hbt_pkg::FUNC_LOOKUP, 48'h48);
    for (int t = 1; t <= 5; t++) begin
      base = t * NUM_SETS * LINE_BYTES + 48'h40;  // same set, new tags
      send_item(hbt_pkg::FUNC_TRAIN, base);
    end
    send_item(hbt_pkg::FUNC_AGE, 48'h5555_5555_5555);
    send_item(hbt_pkg::FUNC_AGE, 48'hAAAA_AAAA_AAAA);
    send_item(hbt_pkg::FUNC_AGE, '0);
    send_item(hbt_pkg::FUNC_LOOKUP, 48'h40);
    send_item(hbt_pkg::FUNC_NONE, 48'h40);
    send_item(hbt_pkg::FUNC_TRAIN, 48'h40);

    random_phase(200, 0, 0);
    random_phase(150, 73, 0);
    random_phase(150, 0, 73);
    random_phase(150, 14, 14);

    // Hold the receiver off while the sender keeps offering items.
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      random_phase(150, 0, 0);
    join
    s_tvalid <= 0;

    wait_cycles = 0;
    while (board.pending.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (2 * NLINES + 20) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
